FILE: sv/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants of the collision triangle classifier
// Request and result layouts, status and class codes, arithmetic widths.
// ----------------------------------------------------------------------------
package ctc_pkg;

    // Store geometry
    localparam int VERTEX_DEPTH_DEF = 4096;

    // Field widths
    localparam int COORD_W = 16;
    localparam int IDX_W   = 16;
    localparam int SLOT_W  = 12;
    localparam int CNT_W   = 13;
    localparam int TYPE_W  = 16;
    localparam int LIM_W   = 17;

    // Arithmetic widths of the normal pipeline
    localparam int DIFF_W  = 17;   // edge vector component
    localparam int PROD_W  = 34;   // one cross product term
    localparam int NORM_W  = 35;   // normal component
    localparam int MAG_W   = 34;   // normal component magnitude
    localparam int HALF_W  = 17;   // half of a magnitude
    localparam int HPROD_W = 34;   // product of two halves
    localparam int SQ_W    = 68;   // squared component
    localparam int SUM_W   = 69;   // sum of two squares
    localparam int LO_W    = 34;   // low slice for the constant scaling
    localparam int KIN_W   = 35;   // slice width fed to a constant multiply
    localparam int K_W     = 19;   // constant width
    localparam int KPROD_W = 54;   // slice times constant
    localparam int WIDE_W  = 90;   // recombined scaled value

    // Exact ratio tests on squared components
    // steep:  9999 * ny^2 > nx^2 + nz^2             (|ny| / |n| > 0.01)
    // x-proj: 500151 * nx^2 > 499849 * (ny^2 + nz^2) (|nx| / |n| > 0.707)
    localparam logic [K_W-1:0] K_STEEP   = 19'd9999;
    localparam logic [K_W-1:0] K_XPROJ_N = 19'd500151;
    localparam logic [K_W-1:0] K_XPROJ_D = 19'd499849;

    // Surface types without camera collision
    localparam logic [TYPE_W-1:0] TYPE_NO_CAM_A = 16'h0076;
    localparam logic [TYPE_W-1:0] TYPE_NO_CAM_B = 16'h0077;
    localparam logic [TYPE_W-1:0] TYPE_NO_CAM_C = 16'h0078;
    localparam logic [TYPE_W-1:0] TYPE_NO_CAM_D = 16'h007A;

    // Request kinds
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_SURFACE = 1'b1;

    // Surface classes
    localparam logic [1:0] CLASS_FLOOR   = 2'd0;
    localparam logic [1:0] CLASS_CEILING = 2'd1;
    localparam logic [1:0] CLASS_WALL    = 2'd2;

    // Result queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int CREDIT_W   = 5;

    typedef enum logic [1:0] {
        STAT_CLASSIFIED = 2'd0,
        STAT_WRITTEN    = 2'd1,
        STAT_RANGE      = 2'd2,
        STAT_DEGENERATE = 2'd3
    } status_t;

    // Read sequencer states
    typedef enum logic [1:0] {
        SEQ_ISSUE,
        SEQ_READ_B,
        SEQ_READ_C
    } seq_state_t;

    // What the store port did in the previous cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_RANGE,
        OP_READ_A,
        OP_READ_B,
        OP_READ_C
    } port_op_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vertex_t;

    localparam int VERTEX_W = $bits(vertex_t);

    typedef struct packed {
        logic                      req_type;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [IDX_W-1:0]          first_index;
        logic [IDX_W-1:0]          second_index;
        logic [IDX_W-1:0]          third_index;
        logic [TYPE_W-1:0]         surface_type;
    } req_t;

    // One job handed from the sequencer to the normal pipeline
    typedef struct packed {
        logic    valid;
        status_t kind;
        logic    no_cam;
        vertex_t a;
        vertex_t b;
        vertex_t c;
    } job_t;

    typedef struct packed {
        status_t                   status;
        logic [1:0]                surface_class;
        logic                      no_cam;
        logic                      x_proj;
        logic signed [COORD_W-1:0] lower;
        logic signed [COORD_W-1:0] upper;
    } result_t;

endpackage

FILE: sv/ctc_vertex_ram.sv
// ----------------------------------------------------------------------------
// ctc_vertex_ram: single-port vertex store
// One read or one write per cycle, read data registered.
// ----------------------------------------------------------------------------
module ctc_vertex_ram
    import ctc_pkg::*;
#(
    parameter int  DEPTH = VERTEX_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  vertex_t       wdata,
    output vertex_t       rdata
);

    vertex_t mem [DEPTH];

    // Write or read the addressed entry
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

FILE: sv/ctc_fetch.sv
// ----------------------------------------------------------------------------
// ctc_fetch: request sequencer on the vertex store port
// Writes vertices, checks surface indices and reads the three vertices.
// ----------------------------------------------------------------------------
module ctc_fetch
    import ctc_pkg::*;
#(
    parameter int  VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    localparam int AW           = $clog2(VERTEX_DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] vertex_count,
    input  req_t             req,
    input  logic             req_fire,
    output logic             seq_ready,
    output logic             ram_en,
    output logic             ram_we,
    output logic [AW-1:0]    ram_addr,
    output vertex_t          ram_wdata,
    input  vertex_t          ram_rdata,
    output job_t             job
);

    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(VERTEX_DEPTH);

    seq_state_t     state_reg, state_next;
    port_op_t       op_reg, op_next;
    logic [AW-1:0]  idx_b_reg, idx_c_reg;
    logic           no_cam_reg;
    vertex_t        a_reg, b_reg;
    logic [LIM_W-1:0] count_ext, limit;
    logic           range_bad, slot_ok;

    function automatic logic is_no_cam(input logic [TYPE_W-1:0] t);
        is_no_cam = (t == TYPE_NO_CAM_A) || (t == TYPE_NO_CAM_B) ||
                    (t == TYPE_NO_CAM_C) || (t == TYPE_NO_CAM_D);
    endfunction

    // Index limit is the smaller of the configured count and the store depth
    assign count_ext = LIM_W'(vertex_count);
    assign limit     = (count_ext < DEPTH_LIM) ? count_ext : DEPTH_LIM;
    assign range_bad = (LIM_W'(req.first_index) >= limit) ||
                       (LIM_W'(req.second_index) >= limit) ||
                       (LIM_W'(req.third_index) >= limit);
    assign slot_ok   = LIM_W'(req.slot) < DEPTH_LIM;

    assign seq_ready = (state_reg == SEQ_ISSUE);
    assign ram_wdata = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};

    // Next state and store port control
    always_comb begin
        state_next = state_reg;
        op_next    = OP_NONE;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = '0;
        case (state_reg)
            SEQ_ISSUE: begin
                if (req_fire) begin
                    if (req.req_type == REQ_WRITE) begin
                        ram_en   = slot_ok;
                        ram_we   = slot_ok;
                        ram_addr = AW'(req.slot);
                        op_next  = OP_WRITE;
                    end else if (range_bad) begin
                        op_next  = OP_RANGE;
                    end else begin
                        ram_en     = 1'b1;
                        ram_addr   = AW'(req.first_index);
                        op_next    = OP_READ_A;
                        state_next = SEQ_READ_B;
                    end
                end
            end
            SEQ_READ_B: begin
                ram_en     = 1'b1;
                ram_addr   = idx_b_reg;
                op_next    = OP_READ_B;
                state_next = SEQ_READ_C;
            end
            SEQ_READ_C: begin
                ram_en     = 1'b1;
                ram_addr   = idx_c_reg;
                op_next    = OP_READ_C;
                state_next = SEQ_ISSUE;
            end
            default: begin
                state_next = SEQ_ISSUE;
            end
        endcase
    end

    // Emit a job for a write, a range fault or the third read of the previous cycle
    always_comb begin
        job = '0;
        case (op_reg)
            OP_WRITE: begin
                job.valid = 1'b1;
                job.kind  = STAT_WRITTEN;
            end
            OP_RANGE: begin
                job.valid = 1'b1;
                job.kind  = STAT_RANGE;
            end
            OP_READ_C: begin
                job.valid  = 1'b1;
                job.kind   = STAT_CLASSIFIED;
                job.no_cam = no_cam_reg;
                job.a      = a_reg;
                job.b      = b_reg;
                job.c      = ram_rdata;
            end
            default: begin
                job.valid = 1'b0;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_ISSUE;
            op_reg    <= OP_NONE;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // Hold the pending indices and collect the first two vertices
    always_ff @(posedge aclk) begin
        if (req_fire) begin
            idx_b_reg  <= AW'(req.second_index);
            idx_c_reg  <= AW'(req.third_index);
            no_cam_reg <= is_no_cam(req.surface_type);
        end
        if (op_reg == OP_READ_A) begin
            a_reg <= ram_rdata;
        end
        if (op_reg == OP_READ_B) begin
            b_reg <= ram_rdata;
        end
    end

endmodule

FILE: sv/ctc_normal.sv
// ----------------------------------------------------------------------------
// ctc_normal: face normal and classification pipeline
// Eight stages: edges, cross terms, normal, half products, squares, sums,
// constant scaling, compare and result.
// ----------------------------------------------------------------------------
module ctc_normal
    import ctc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  job_t    job,
    output logic    res_valid,
    output result_t res
);

    typedef struct packed {
        status_t                   status;
        logic                      no_cam;
        logic signed [COORD_W-1:0] lower;
        logic signed [COORD_W-1:0] upper;
    } tag_t;

    function automatic logic [HPROD_W-1:0] umul(input logic [HALF_W-1:0] a,
                                                input logic [HALF_W-1:0] b);
        umul = HPROD_W'(a) * HPROD_W'(b);
    endfunction

    function automatic logic [KPROD_W-1:0] kmul(input logic [KIN_W-1:0] a,
                                                input logic [K_W-1:0]   k);
        kmul = KPROD_W'(a) * KPROD_W'(k);
    endfunction

    // Stage valids
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg, res_vld_reg;

    // Stage payloads
    tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    tag_t s5_tag_reg, s6_tag_reg, s7_tag_reg;
    logic signed [DIFF_W-1:0] s1_u_reg [3];
    logic signed [DIFF_W-1:0] s1_v_reg [3];
    logic signed [PROD_W-1:0] s2_p_reg [6];
    logic signed [NORM_W-1:0] s3_n_reg [3];
    logic [HPROD_W-1:0] s4_hh_reg [3];
    logic [HPROD_W-1:0] s4_hl_reg [3];
    logic [HPROD_W-1:0] s4_ll_reg [3];
    logic s4_zero_reg, s5_zero_reg, s6_zero_reg, s7_zero_reg;
    logic s4_yneg_reg, s5_yneg_reg, s6_yneg_reg, s7_yneg_reg;
    logic [SQ_W-1:0]    s5_sq_reg [3];
    logic [SQ_W-1:0]    s6_sqx_reg, s6_sqy_reg;
    logic [SUM_W-1:0]   s6_r1_reg, s6_r2_reg, s7_r1_reg;
    logic [KPROD_W-1:0] s7_fy_lo_reg, s7_fy_hi_reg;
    logic [KPROD_W-1:0] s7_gx_lo_reg, s7_gx_hi_reg;
    logic [KPROD_W-1:0] s7_gr_lo_reg, s7_gr_hi_reg;
    result_t            res_reg, res_next;

    // Stage 1 inputs: vertical extent
    logic signed [COORD_W-1:0] y_lo_ab, y_hi_ab, y_min, y_max;
    tag_t s1_tag_next;

    // Stage 4 inputs: magnitudes
    logic [NORM_W-1:0] abs_n [3];
    logic [MAG_W-1:0]  mag_n [3];

    // Stage 8 inputs: recombined scaled values
    logic [WIDE_W-1:0] fy_full, gx_full, gr_full;
    logic              steep, x_major;

    always_comb begin
        y_lo_ab = ($signed(job.a.y) < $signed(job.b.y)) ? job.a.y : job.b.y;
        y_hi_ab = ($signed(job.a.y) > $signed(job.b.y)) ? job.a.y : job.b.y;
        y_min   = ($signed(job.c.y) < y_lo_ab) ? job.c.y : y_lo_ab;
        y_max   = ($signed(job.c.y) > y_hi_ab) ? job.c.y : y_hi_ab;
        s1_tag_next.status = job.kind;
        s1_tag_next.no_cam = job.no_cam;
        s1_tag_next.lower  = y_min - 16'sd5;
        s1_tag_next.upper  = y_max + 16'sd5;
    end

    // Take magnitudes of the normal components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_n[i] = s3_n_reg[i][NORM_W-1] ? NORM_W'(-s3_n_reg[i]) : s3_n_reg[i];
            mag_n[i] = abs_n[i][MAG_W-1:0];
        end
    end

    // Recombine the scaled slices and compare
    always_comb begin
        fy_full = (WIDE_W'(s7_fy_hi_reg) << LO_W) + WIDE_W'(s7_fy_lo_reg);
        gx_full = (WIDE_W'(s7_gx_hi_reg) << LO_W) + WIDE_W'(s7_gx_lo_reg);
        gr_full = (WIDE_W'(s7_gr_hi_reg) << LO_W) + WIDE_W'(s7_gr_lo_reg);
        steep   = fy_full > WIDE_W'(s7_r1_reg);
        x_major = gx_full > gr_full;
    end

    // Form the result
    always_comb begin
        res_next        = '0;
        res_next.status = s7_tag_reg.status;
        case (s7_tag_reg.status)
            STAT_CLASSIFIED: begin
                res_next.no_cam = s7_tag_reg.no_cam;
                if (s7_zero_reg) begin
                    res_next.status = STAT_DEGENERATE;
                end else begin
                    if (steep) begin
                        res_next.surface_class = s7_yneg_reg ? CLASS_CEILING : CLASS_FLOOR;
                    end else begin
                        res_next.surface_class = CLASS_WALL;
                        res_next.x_proj        = x_major;
                    end
                    res_next.lower = s7_tag_reg.lower;
                    res_next.upper = s7_tag_reg.upper;
                end
            end
            default: begin
                res_next.status = s7_tag_reg.status;
            end
        endcase
    end

    // Advance stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg  <= job.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            res_vld_reg <= s7_vld_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge aclk) begin
        // edge vectors u = b - a, v = c - a
        s1_tag_reg  <= s1_tag_next;
        s1_u_reg[0] <= DIFF_W'($signed(job.b.x)) - DIFF_W'($signed(job.a.x));
        s1_u_reg[1] <= DIFF_W'($signed(job.b.y)) - DIFF_W'($signed(job.a.y));
        s1_u_reg[2] <= DIFF_W'($signed(job.b.z)) - DIFF_W'($signed(job.a.z));
        s1_v_reg[0] <= DIFF_W'($signed(job.c.x)) - DIFF_W'($signed(job.a.x));
        s1_v_reg[1] <= DIFF_W'($signed(job.c.y)) - DIFF_W'($signed(job.a.y));
        s1_v_reg[2] <= DIFF_W'($signed(job.c.z)) - DIFF_W'($signed(job.a.z));

        // cross product terms
        s2_tag_reg  <= s1_tag_reg;
        s2_p_reg[0] <= PROD_W'(s1_u_reg[1]) * PROD_W'(s1_v_reg[2]);
        s2_p_reg[1] <= PROD_W'(s1_u_reg[2]) * PROD_W'(s1_v_reg[1]);
        s2_p_reg[2] <= PROD_W'(s1_u_reg[2]) * PROD_W'(s1_v_reg[0]);
        s2_p_reg[3] <= PROD_W'(s1_u_reg[0]) * PROD_W'(s1_v_reg[2]);
        s2_p_reg[4] <= PROD_W'(s1_u_reg[0]) * PROD_W'(s1_v_reg[1]);
        s2_p_reg[5] <= PROD_W'(s1_u_reg[1]) * PROD_W'(s1_v_reg[0]);

        // normal components
        s3_tag_reg <= s2_tag_reg;
        for (int i = 0; i < 3; i++) begin
            s3_n_reg[i] <= NORM_W'(s2_p_reg[2*i]) - NORM_W'(s2_p_reg[2*i+1]);
        end

        // split each magnitude into halves and multiply the halves
        s4_tag_reg  <= s3_tag_reg;
        s4_zero_reg <= (s3_n_reg[0] == '0) && (s3_n_reg[1] == '0) && (s3_n_reg[2] == '0);
        s4_yneg_reg <= s3_n_reg[1][NORM_W-1];
        for (int i = 0; i < 3; i++) begin
            s4_hh_reg[i] <= umul(mag_n[i][MAG_W-1:HALF_W], mag_n[i][MAG_W-1:HALF_W]);
            s4_hl_reg[i] <= umul(mag_n[i][MAG_W-1:HALF_W], mag_n[i][HALF_W-1:0]);
            s4_ll_reg[i] <= umul(mag_n[i][HALF_W-1:0], mag_n[i][HALF_W-1:0]);
        end

        // squares: hh * 2^34 + 2 * hl * 2^17 + ll
        s5_tag_reg  <= s4_tag_reg;
        s5_zero_reg <= s4_zero_reg;
        s5_yneg_reg <= s4_yneg_reg;
        for (int i = 0; i < 3; i++) begin
            s5_sq_reg[i] <= (SQ_W'(s4_hh_reg[i]) << (2 * HALF_W)) +
                            (SQ_W'(s4_hl_reg[i]) << (HALF_W + 1)) +
                            SQ_W'(s4_ll_reg[i]);
        end

        // sums of squares for the two ratio tests
        s6_tag_reg  <= s5_tag_reg;
        s6_zero_reg <= s5_zero_reg;
        s6_yneg_reg <= s5_yneg_reg;
        s6_sqx_reg  <= s5_sq_reg[0];
        s6_sqy_reg  <= s5_sq_reg[1];
        s6_r1_reg   <= SUM_W'(s5_sq_reg[0]) + SUM_W'(s5_sq_reg[2]);
        s6_r2_reg   <= SUM_W'(s5_sq_reg[1]) + SUM_W'(s5_sq_reg[2]);

        // scale by the ratio constants, low and high slices apart
        s7_tag_reg   <= s6_tag_reg;
        s7_zero_reg  <= s6_zero_reg;
        s7_yneg_reg  <= s6_yneg_reg;
        s7_r1_reg    <= s6_r1_reg;
        s7_fy_lo_reg <= kmul(KIN_W'(s6_sqy_reg[LO_W-1:0]), K_STEEP);
        s7_fy_hi_reg <= kmul(KIN_W'(s6_sqy_reg[SQ_W-1:LO_W]), K_STEEP);
        s7_gx_lo_reg <= kmul(KIN_W'(s6_sqx_reg[LO_W-1:0]), K_XPROJ_N);
        s7_gx_hi_reg <= kmul(KIN_W'(s6_sqx_reg[SQ_W-1:LO_W]), K_XPROJ_N);
        s7_gr_lo_reg <= kmul(KIN_W'(s6_r2_reg[LO_W-1:0]), K_XPROJ_D);
        s7_gr_hi_reg <= kmul(KIN_W'(s6_r2_reg[SUM_W-1:LO_W]), K_XPROJ_D);

        res_reg <= res_next;
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

FILE: sv/collision_triangle_classifier.sv
// ----------------------------------------------------------------------------
// Collision triangle classifier: top level
// Throughput: one vertex write per cycle while a result queue slot is free; a
// surface holds off the next request until its three reads on the single
// vertex store port are issued.
// Reset clears control, vertex_count and the result queue; store stays as is.
// ----------------------------------------------------------------------------
module collision_triangle_classifier
    import ctc_pkg::*;
#(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CNT_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [SLOT_W-1:0]         s_vertex_slot,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    input  logic signed [COORD_W-1:0] s_coord_z,
    input  logic [IDX_W-1:0]          s_first_index,
    input  logic [IDX_W-1:0]          s_second_index,
    input  logic [IDX_W-1:0]          s_third_index,
    input  logic [TYPE_W-1:0]         s_surface_type,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [1:0]                m_surface_class,
    output logic                      m_no_cam_flag,
    output logic                      m_x_projection_flag,
    output logic signed [COORD_W-1:0] m_lower_bound,
    output logic signed [COORD_W-1:0] m_upper_bound
);

    localparam int AW = $clog2(VERTEX_DEPTH);

    logic [CNT_W-1:0]    vertex_count_reg;
    req_t                req;
    logic                req_fire, seq_ready, pop;
    logic                ram_en, ram_we;
    logic [AW-1:0]       ram_addr;
    vertex_t             ram_wdata, ram_rdata;
    job_t                job;
    logic                res_valid;
    result_t             res;
    result_t             fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CREDIT_W-1:0] count_reg, count_next;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    result_t             head;

    // Pack the request fields
    assign req.req_type     = s_req_type;
    assign req.slot         = s_vertex_slot;
    assign req.coord_x      = s_coord_x;
    assign req.coord_y      = s_coord_y;
    assign req.coord_z      = s_coord_z;
    assign req.first_index  = s_first_index;
    assign req.second_index = s_second_index;
    assign req.third_index  = s_third_index;
    assign req.surface_type = s_surface_type;

    // Accept only while the sequencer is idle and a queue slot can be reserved for the result
    assign s_ready  = seq_ready && (credit_reg != CREDIT_W'(FIFO_DEPTH));
    assign req_fire = s_valid && s_ready;
    assign pop      = m_valid && m_ready;

    ctc_vertex_ram #(
        .DEPTH (VERTEX_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ctc_fetch #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_fetch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .vertex_count (vertex_count_reg),
        .req          (req),
        .req_fire     (req_fire),
        .seq_ready    (seq_ready),
        .ram_en       (ram_en),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .job          (job)
    );

    ctc_normal u_normal (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (job),
        .res_valid (res_valid),
        .res       (res)
    );

    assign credit_next = credit_reg + CREDIT_W'(req_fire) - CREDIT_W'(pop);
    assign count_next  = count_reg + CREDIT_W'(res_valid) - CREDIT_W'(pop);

    // Configuration register and queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
            credit_reg       <= '0;
            count_reg        <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                vertex_count_reg <= cfg_wr_data;
            end
            credit_reg <= credit_next;
            count_reg  <= count_next;
            if (res_valid) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    // Store finished results
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    assign head                = fifo_mem[rd_ptr_reg];
    assign m_valid             = (count_reg != '0);
    assign m_status            = head.status;
    assign m_surface_class     = head.surface_class;
    assign m_no_cam_flag       = head.no_cam;
    assign m_x_projection_flag = head.x_proj;
    assign m_lower_bound       = head.lower;
    assign m_upper_bound       = head.upper;

endmodule

FILE: sv/ctc_checker.sv
// ----------------------------------------------------------------------------
// ctc_checker: port-level checks of the collision triangle classifier
// Watches the result channel for consistent field combinations.
// ----------------------------------------------------------------------------
module ctc_checker
    import ctc_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [1:0]                m_status,
    input logic [1:0]                m_surface_class,
    input logic                      m_no_cam_flag,
    input logic                      m_x_projection_flag,
    input logic signed [COORD_W-1:0] m_lower_bound,
    input logic signed [COORD_W-1:0] m_upper_bound
);

    // A stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Write and range answers carry nothing else
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_WRITTEN || m_status == STAT_RANGE) |->
        m_surface_class == CLASS_FLOOR && !m_no_cam_flag && !m_x_projection_flag &&
        m_lower_bound == '0 && m_upper_bound == '0)
        else $error("write or range answer with nonzero fields");

    // Degenerate answers carry only the no-camera flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_DEGENERATE |->
        m_surface_class == CLASS_FLOOR && !m_x_projection_flag &&
        m_lower_bound == '0 && m_upper_bound == '0)
        else $error("degenerate answer with class or bounds");

    // X-projection only on classified walls
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_x_projection_flag |->
        m_status == STAT_CLASSIFIED && m_surface_class == CLASS_WALL)
        else $error("x-projection outside a wall");

    // Class code is always a defined class
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_surface_class == CLASS_FLOOR ||
        m_surface_class == CLASS_CEILING || m_surface_class == CLASS_WALL)
        else $error("undefined surface class");

endmodule

bind collision_triangle_classifier ctc_checker u_ctc_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_status            (m_status),
    .m_surface_class     (m_surface_class),
    .m_no_cam_flag       (m_no_cam_flag),
    .m_x_projection_flag (m_x_projection_flag),
    .m_lower_bound       (m_lower_bound),
    .m_upper_bound       (m_upper_bound)
);
